[sv/ahcd_pkg.sv]
// Shared constants and helper functions for the ASCII-hex CRC-16 deframer.
// No dependencies; imported by the deframer top level.
package ahcd_pkg;

   localparam logic [7:0]  LEN_SHORT      = 8'h02;
   localparam logic [7:0]  LEN_LONG       = 8'h42;
   localparam logic [6:0]  CHARS_SHORT    = 7'd2;
   localparam logic [6:0]  CHARS_LONG     = 7'd66;
   localparam logic [6:0]  CHARS_CRC      = 7'd4;
   localparam logic [5:0]  BYTES_SHORT    = 6'd1;
   localparam logic [5:0]  BYTES_LONG     = 6'd33;
   localparam logic [5:0]  BAL_FIRST_BYTE = 6'd10;
   localparam logic [5:0]  BAL_LAST_BYTE  = 6'd13;
   localparam logic [15:0] CRC_POLY       = 16'h1021;
   localparam logic [7:0]  START_RESET    = 8'h02;
   localparam logic [7:0]  END_RESET      = 8'h03;

   localparam logic [1:0]  STATUS_OK      = 2'd0;
   localparam logic [1:0]  STATUS_CRC_ERR = 2'd1;
   localparam logic [1:0]  STATUS_END_ERR = 2'd2;

   localparam logic        CSR_START_CHAR = 1'b0;
   localparam logic        CSR_END_CHAR   = 1'b1;

   // digits give c - '0'; anything else gives c - 0x37, unchecked
   function automatic logic [7:0] nib_val(input logic [7:0] c);
      logic [7:0] v;
      if (c > 8'h2f && c < 8'h3a) begin
         v = c - 8'h30;
      end else begin
         v = c - 8'h37;
      end
      return v;
   endfunction

   // low value is deliberately not masked to four bits
   function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
      logic [7:0] h;
      h = nib_val(hi);
      return {h[3:0], 4'h0} | nib_val(lo);
   endfunction

   // one byte of CRC-16/XMODEM, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

[sv/ascii_hex_crc16_deframer.sv]
// ASCII-hex framed receiver with CRC-16/XMODEM check, one character per word.
// Depends on ahcd_pkg for constants, hex decode and the byte-wide CRC step.

// Takes one received character per clock unless req_stall holds it, and gives
// one result word per completed frame (start, two length characters giving
// 0x02 or 0x42, payload, four CRC characters low byte first, end character).
// Every character is handled by the byte-wide CRC step and nibble decode that
// sit between the frame state registers; the result goes to an output
// register and is valid the cycle after the end character is taken, so
// characters keep flowing while a result waits. req_stall is high only while
// the block waits for the end character of a frame and the previous result is
// still held by a stalled consumer. Configuration (start and end character)
// must be written by the user only while no frame is in progress; unchecked.
module ascii_hex_crc16_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_frame_status,
   output logic [7:0] rsp_ack_code,
   output logic [31:0] rsp_balance,
   output logic       rsp_long_frame,
   output logic [5:0] rsp_data_count
);
   import ahcd_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD, PH_CRC, PH_END
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [6:0]  count_ff, count_in;
   logic        long_ff, long_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  high_ff, high_in;
   logic [7:0]  first_ff, first_in;
   logic [31:0] bal_ff, bal_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [7:0]  start_char_ff, end_char_ff;

   logic        rsp_valid_ff;
   logic [1:0]  status_ff;
   logic [7:0]  ack_ff;
   logic [31:0] balance_ff;
   logic        rsp_long_ff;
   logic [5:0]  dcount_ff;

   logic        accept;
   logic        emit;
   logic [1:0]  status_in;

   assign req_stall = rsp_valid_ff && rsp_stall && (phase_ff == PH_END);
   assign accept    = req_valid && !req_stall;
   assign emit      = accept && (phase_ff == PH_END);

   always_comb begin
      logic [7:0] c;
      logic [7:0] pair;
      logic [6:0] cnt_next;
      logic [5:0] j;
      logic [5:0] bidx;

      c        = req_rx_byte;
      pair     = hex_pair(high_ff, c);
      cnt_next = count_ff + 7'd1;
      j        = count_ff[6:1];
      bidx     = j - BAL_FIRST_BYTE;

      phase_in  = phase_ff;
      count_in  = count_ff;
      long_in   = long_ff;
      crc_in    = crc_ff;
      high_in   = high_ff;
      first_in  = first_ff;
      bal_in    = bal_ff;
      rx_crc_in = rx_crc_ff;

      if (crc_ff != rx_crc_ff) begin
         status_in = STATUS_CRC_ERR;
      end else if (c != end_char_ff) begin
         status_in = STATUS_END_ERR;
      end else begin
         status_in = STATUS_OK;
      end

      case (phase_ff)
         PH_LEN_HI: begin
            high_in  = c;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            if (pair == LEN_SHORT || pair == LEN_LONG) begin
               long_in  = (pair == LEN_LONG);
               count_in = '0;
               phase_in = PH_PAYLOAD;
            end else if (c == start_char_ff || high_ff == start_char_ff) begin
               // restart a frame; a start in the first length slot makes
               // this character the new first length character
               phase_in  = (c == start_char_ff) ? PH_LEN_HI : PH_LEN_LO;
               high_in   = (c == start_char_ff) ? 8'h00 : c;
               count_in  = '0;
               long_in   = 1'b0;
               crc_in    = '0;
               first_in  = '0;
               bal_in    = '0;
               rx_crc_in = '0;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_PAYLOAD: begin
            crc_in = crc_byte(crc_ff, c);
            if (!count_ff[0]) begin
               high_in = c;
            end else if (j == '0) begin
               first_in = pair;
            end else if (j >= BAL_FIRST_BYTE && j <= BAL_LAST_BYTE) begin
               bal_in = bal_ff | ({24'h0, pair} << {bidx[1:0], 3'b000});
            end
            count_in = cnt_next;
            if (cnt_next >= (long_ff ? CHARS_LONG : CHARS_SHORT)) begin
               count_in = '0;
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            if (!count_ff[0]) begin
               high_in = c;
            end else if (count_ff[1]) begin
               rx_crc_in = {pair, rx_crc_ff[7:0]};
            end else begin
               rx_crc_in = {rx_crc_ff[15:8], pair};
            end
            count_in = cnt_next;
            if (cnt_next >= CHARS_CRC) begin
               count_in = '0;
               phase_in = PH_END;
            end
         end
         PH_END: begin
            phase_in = PH_HUNT;
            count_in = '0;
         end
         default: begin
            if (c == start_char_ff) begin
               phase_in  = PH_LEN_HI;
               count_in  = '0;
               long_in   = 1'b0;
               crc_in    = '0;
               high_in   = '0;
               first_in  = '0;
               bal_in    = '0;
               rx_crc_in = '0;
            end else begin
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         count_ff      <= '0;
         long_ff       <= 1'b0;
         crc_ff        <= '0;
         high_ff       <= '0;
         first_ff      <= '0;
         bal_ff        <= '0;
         rx_crc_ff     <= '0;
         start_char_ff <= START_RESET;
         end_char_ff   <= END_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_START_CHAR: start_char_ff <= csr_data;
               CSR_END_CHAR:   end_char_ff   <= csr_data;
               default: begin
               end
            endcase
         end
         if (accept) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            long_ff   <= long_in;
            crc_ff    <= crc_in;
            high_ff   <= high_in;
            first_ff  <= first_in;
            bal_ff    <= bal_in;
            rx_crc_ff <= rx_crc_in;
         end
         // drop the held word once taken, load a new one on frame end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         status_ff   <= status_in;
         ack_ff      <= first_ff;
         balance_ff  <= long_ff ? bal_ff : 32'h0;
         rsp_long_ff <= long_ff;
         dcount_ff   <= long_ff ? BYTES_LONG : BYTES_SHORT;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_ack_code     = ack_ff;
   assign rsp_balance      = balance_ff;
   assign rsp_long_frame   = rsp_long_ff;
   assign rsp_data_count   = dcount_ff;

endmodule
